// ----- rtl/pdu_pkg.sv -----
package pdu_pkg;

   localparam int MaxChars          = 9;
   localparam int QueueDepthDefault = 2;
   localparam int CountWidth        = $clog2(MaxChars + 1);
   localparam int IndexWidth        = $clog2(MaxChars);

   typedef enum logic [1:0] {
      StatusOk         = 2'd0,
      StatusBadPrefix  = 2'd1,
      StatusBadCentury = 2'd2,
      StatusBadCycle   = 2'd3
   } status_type;

   // One decoded designation, waiting to be serialized.
   typedef struct packed {
      logic [MaxChars-1:0][7:0] chars;
      logic [CountWidth-1:0]    count;
      logic                     has_char;
      status_type               status;
   } entry_type;

endpackage

// ----- rtl/pdu_front.sv -----
module pdu_front (
   input  logic [11:0][7:0]   id_chars,
   output pdu_pkg::entry_type entry
);
   import pdu_pkg::*;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharOne   = 8'h31;
   localparam logic [7:0] CharTwo   = 8'h32;
   localparam logic [7:0] CharEight = 8'h38;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CharLoA   = 8'h61;
   localparam logic [7:0] CharLoZ   = 8'h7A;
   localparam logic [7:0] CharI     = 8'h49;
   localparam logic [7:0] CharJ     = 8'h4A;
   localparam logic [7:0] CharK     = 8'h4B;
   localparam logic [7:0] CharS     = 8'h53;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;
   localparam logic [7:0] CharCr    = 8'h0D;

   function automatic logic is_ws(logic [7:0] ch);
      return (ch == CharSpace) || (ch >= CharTab && ch <= CharCr);
   endfunction

   function automatic logic is_dig(logic [7:0] ch);
      return ch >= CharZero && ch <= CharNine;
   endfunction

   function automatic logic is_up(logic [7:0] ch);
      return ch >= CharUpA && ch <= CharUpZ;
   endfunction

   function automatic logic is_lo(logic [7:0] ch);
      return ch >= CharLoA && ch <= CharLoZ;
   endfunction

   // Letter code to two ASCII digits: A-Z is 10-35, a-z is 36-61.
   function automatic logic [15:0] letter_digits(logic [7:0] ch);
      logic [5:0] v;
      logic [2:0] t;
      logic [5:0] u;
      if (is_up(ch)) begin
         v = 6'(ch - CharUpA) + 6'd10;
      end else begin
         v = 6'(ch - CharLoA) + 6'd36;
      end
      if (v >= 6'd60)      t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else                 t = 3'd1;
      u = v - 6'({3'b0, t} * 6'd10);
      return {CharZero + {5'b0, t}, CharZero + {2'b0, u}};
   endfunction

   logic              numbered;
   logic [2:0]        lead;
   logic              seen;
   logic [3:0]        sel;
   logic [15:0]       pre;
   logic [15:0]       cyc;
   logic [7:0]        hi_c;
   logic [7:0]        lo_c;

   always_comb begin
      entry          = '0;
      entry.status   = StatusOk;
      entry.has_char = 1'b1;
      numbered       = 1'b1;
      lead           = 3'd0;
      seen           = 1'b0;
      sel            = 4'd0;
      pre            = letter_digits(id_chars[0]);
      hi_c           = id_chars[9];
      lo_c           = id_chars[10];
      cyc            = letter_digits(hi_c);

      for (int k = 0; k < 5; k++) begin
         if (is_ws(id_chars[k])) numbered = 1'b0;
      end

      if (numbered) begin
         if (is_dig(id_chars[0])) begin
            for (int k = 0; k < 5; k++) begin
               if (!seen && id_chars[k] == CharZero) lead = lead + 3'd1;
               else seen = 1'b1;
            end
            // shift out the leading zeros
            for (int j = 0; j < 5; j++) begin
               sel = 4'(j) + {1'b0, lead};
               if (sel < 4'd5) entry.chars[j] = id_chars[sel];
            end
            entry.count = CountWidth'(4'd5 - {1'b0, lead});
            if (lead == 3'd5) begin
               entry.count    = CountWidth'(1);
               entry.has_char = 1'b0;
            end
         end else if (is_up(id_chars[0]) || is_lo(id_chars[0])) begin
            entry.chars[0] = pre[15:8];
            entry.chars[1] = pre[7:0];
            for (int j = 1; j < 5; j++) entry.chars[j+1] = id_chars[j];
            entry.count = CountWidth'(6);
         end else begin
            entry.count    = CountWidth'(1);
            entry.has_char = 1'b0;
            entry.status   = StatusBadPrefix;
         end
      end else if (id_chars[7] == CharS) begin
         entry.chars[0] = id_chars[8];
         entry.chars[1] = id_chars[9];
         entry.chars[2] = id_chars[10];
         entry.chars[3] = id_chars[11];
         entry.chars[4] = id_chars[5];
         entry.chars[5] = CharDash;
         entry.chars[6] = id_chars[6];
         entry.count    = CountWidth'(7);
      end else if (id_chars[5] == CharI || id_chars[5] == CharJ
                   || id_chars[5] == CharK) begin
         if (id_chars[5] == CharI) begin
            entry.chars[0] = CharOne;
            entry.chars[1] = CharEight;
         end else if (id_chars[5] == CharJ) begin
            entry.chars[0] = CharOne;
            entry.chars[1] = CharNine;
         end else begin
            entry.chars[0] = CharTwo;
            entry.chars[1] = CharZero;
         end
         entry.chars[2] = id_chars[6];
         entry.chars[3] = id_chars[7];
         entry.chars[4] = id_chars[8];
         entry.chars[5] = id_chars[11];
         if (hi_c == CharZero && lo_c == CharZero) begin
            entry.count = CountWidth'(6);
         end else if (hi_c == CharZero) begin
            entry.chars[6] = lo_c;
            entry.count    = CountWidth'(7);
         end else if (is_dig(hi_c)) begin
            entry.chars[6] = hi_c;
            entry.chars[7] = lo_c;
            entry.count    = CountWidth'(8);
         end else if (is_up(hi_c) || is_lo(hi_c)) begin
            entry.chars[6] = cyc[15:8];
            entry.chars[7] = cyc[7:0];
            entry.chars[8] = lo_c;
            entry.count    = CountWidth'(9);
         end else begin
            entry.chars    = '0;
            entry.count    = CountWidth'(1);
            entry.has_char = 1'b0;
            entry.status   = StatusBadCycle;
         end
      end else begin
         entry.count    = CountWidth'(1);
         entry.has_char = 1'b0;
         entry.status   = StatusBadCentury;
      end

      // characterless results always carry a zero byte
      if (!entry.has_char) entry.chars = '0;
   end

endmodule

// ----- rtl/pdu_queue.sv -----
module pdu_queue #(
   parameter int Depth = pdu_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pdu_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output pdu_pkg::entry_type pop_entry
);
   import pdu_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);

   entry_type             mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full      = (count_ff == CntWidth'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ----- rtl/pdu_back.sv -----
module pdu_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  pdu_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_char,
   output logic               rsp_char_valid,
   output logic               rsp_last,
   output logic [1:0]         rsp_status
);
   import pdu_pkg::*;

   entry_type             cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [IndexWidth-1:0] idx_ff, idx_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_char_ff, out_char_in;
   logic                  out_cv_ff, out_cv_in;
   logic                  out_last_ff, out_last_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic                  advance;
   logic                  at_last;

   assign advance = cur_valid_ff && (!out_valid_ff || !rsp_stall);
   assign at_last = ({1'b0, idx_ff} + 1'b1) == (CountWidth + 1)'(cur_ff.count);
   assign q_pop   = q_valid && (!cur_valid_ff || (advance && at_last));

   always_comb begin
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff;
      out_char_in   = out_char_ff;
      out_cv_in     = out_cv_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;

      // drop the output word once taken
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;

      if (advance) begin
         out_valid_in  = 1'b1;
         out_char_in   = cur_ff.chars[idx_ff];
         out_cv_in     = cur_ff.has_char;
         out_last_in   = at_last;
         out_status_in = at_last ? cur_ff.status : StatusOk;
         idx_in        = idx_ff + 1'b1;
         if (at_last) cur_valid_in = 1'b0;
      end

      if (q_pop) begin
         cur_in       = q_entry;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_char_ff   <= out_char_in;
      out_cv_ff     <= out_cv_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_char_valid = out_cv_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_status     = out_status_ff;

endmodule

// ----- rtl/packed_designation_unpacker.sv -----
// Packed designation unpacker. Each request word carries the twelve identifier
// columns of one record; the block decodes it in the cycle it is accepted and
// parks the decoded designation in a small queue (QueueDepth entries). The
// serializer then sends one response word per cycle while rsp_stall is low,
// one character each, with rsp_last on the final one; a record yields 1 to 9
// words, and records waiting in the queue follow each other without a gap.
// Numbered, survey and provisional forms are handled; a bad prefix, unknown
// century or bad cycle character gives a single characterless word with
// rsp_status set, and an all-zero number gives one with rsp_status left at
// StatusOk. req_stall rises only when the queue is full.
module packed_designation_unpacker #(
   parameter int QueueDepth = pdu_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_id_char_0,
   input  logic [7:0] req_id_char_1,
   input  logic [7:0] req_id_char_2,
   input  logic [7:0] req_id_char_3,
   input  logic [7:0] req_id_char_4,
   input  logic [7:0] req_id_char_5,
   input  logic [7:0] req_id_char_6,
   input  logic [7:0] req_id_char_7,
   input  logic [7:0] req_id_char_8,
   input  logic [7:0] req_id_char_9,
   input  logic [7:0] req_id_char_10,
   input  logic [7:0] req_id_char_11,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_last,
   output logic [1:0] rsp_status
);
   import pdu_pkg::*;

   logic [11:0][7:0] id_chars;
   entry_type        dec_entry;
   entry_type        q_entry;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;

   assign id_chars = {req_id_char_11, req_id_char_10, req_id_char_9, req_id_char_8,
                      req_id_char_7, req_id_char_6, req_id_char_5, req_id_char_4,
                      req_id_char_3, req_id_char_2, req_id_char_1, req_id_char_0};

   assign req_stall = q_full;

   pdu_front u_front (
      .id_chars (id_chars),
      .entry    (dec_entry)
   );

   pdu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_entry (dec_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   pdu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

// ----- rtl/pdu_checker.sv -----
module pdu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_char_valid,
   input logic       rsp_last,
   input logic [1:0] rsp_status
);
   import pdu_pkg::*;

   // hold a stalled response word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char)
                                 && $stable(rsp_last) && $stable(rsp_status))
      else $error("stalled response word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_last && rsp_out_char == 8'd0)
      else $error("characterless word is not a final zero word");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_char_valid && rsp_status == StatusOk)
      else $error("inner word carries status or no character");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StatusOk |-> !rsp_char_valid)
      else $error("error status on a character word");

endmodule

bind packed_designation_unpacker pdu_checker u_pdu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_char   (rsp_out_char),
   .rsp_char_valid (rsp_char_valid),
   .rsp_last       (rsp_last),
   .rsp_status     (rsp_status)
);
